FILE: hw/rtl/mpl_pkg.sv
// Shared types, widths, register codes and saturation helpers of the motor
// power limiter. No dependencies; every other file depends on this package.
`default_nettype none

package mpl_pkg;

	localparam int CUR_W      = 16;
	localparam int SPD_W      = 16;
	localparam int PWR_W      = 32;
	localparam int COEF_W     = 32;
	localparam int SCALE_W    = 17;
	localparam int LIMIT_W    = 15;
	localparam int GAIN_W     = 24;
	localparam int DRIVE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int SQRT_BITS_DEF = 32;
	localparam int ROOT_W        = 32;
	localparam int DISC_W        = 64;
	localparam int REM_W         = 66;
	localparam int NUM_W         = 44;
	localparam int DEN_W         = 32;

	localparam logic [SCALE_W-1:0] SCALE_ONE = 17'd65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd20480;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd209715;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_K0     = 3'd0,
		CFG_K1     = 3'd1,
		CFG_K2     = 3'd2,
		CFG_A      = 3'd3,
		CFG_SCALE  = 3'd4,
		CFG_ENABLE = 3'd5,
		CFG_LIMIT  = 3'd6,
		CFG_GAIN   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] k0;
		logic signed [COEF_W-1:0] k1;
		logic signed [COEF_W-1:0] k2;
		logic signed [COEF_W-1:0] a;
		logic [SCALE_W-1:0]       scale;
		logic                     enable;
		logic [LIMIT_W-1:0]       limit;
		logic [GAIN_W-1:0]        gain;
	} cfg_t;

	typedef struct packed {
		logic signed [CUR_W-1:0] cur;
		logic signed [CUR_W-1:0] ff;
		logic signed [PWR_W-1:0] p;
		logic signed [PWR_W-1:0] b;
		logic                    applied;
		logic                    nosol;
	} item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [CUR_W-1:0]   lcur;
		logic signed [PWR_W-1:0]   p;
		logic                      applied;
		logic                      nosol;
	} res_t;

	function automatic logic signed [PWR_W-1:0] sat_s32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) return 32'sh8000_0000;
		else return v[PWR_W-1:0];
	endfunction

	function automatic logic signed [CUR_W-1:0] sat_s16(input logic signed [63:0] v);
		if (v > 64'sd32767) return 16'sh7FFF;
		else if (v < -64'sd32768) return 16'sh8000;
		else return v[CUR_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/mpl_in_if.sv
// Input channel of the motor power limiter: valid, ready and one command beat.
// Depends on mpl_pkg for field widths.
`default_nettype none

interface mpl_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [mpl_pkg::CUR_W-1:0] command_current;
	logic signed [mpl_pkg::CUR_W-1:0] extra_current;
	logic signed [mpl_pkg::SPD_W-1:0] shaft_speed;

	modport source(output valid, output command_current, output extra_current,
		output shaft_speed, input ready);
	modport sink(input valid, input command_current, input extra_current,
		input shaft_speed, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpl_out_if.sv
// Result channel of the motor power limiter: valid, ready and one result beat.
// Depends on mpl_pkg for field widths.
`default_nettype none

interface mpl_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [mpl_pkg::DRIVE_W-1:0] drive_word;
	logic signed [mpl_pkg::CUR_W-1:0]   limited_current;
	logic signed [mpl_pkg::PWR_W-1:0]   power_est;
	logic                               limit_applied;
	logic                               no_solution;

	modport source(output valid, output drive_word, output limited_current,
		output power_est, output limit_applied, output no_solution, input ready);
	modport sink(input valid, input drive_word, input limited_current,
		input power_est, input limit_applied, input no_solution, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mpl_front.sv
// Front pipeline: power estimate and quarter discriminant, eight stages.
// Depends on mpl_pkg and mpl_in_if.
`default_nettype none

module mpl_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  mpl_pkg::cfg_t                cfg,
	mpl_in_if.sink                       cmd,
	output logic                         out_v,
	output logic [mpl_pkg::DISC_W-1:0]   out_d,
	output mpl_pkg::item_t               out_item
);
	import mpl_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic signed [CUR_W-1:0] cur_s1, cur_s2, cur_s3, cur_s4, cur_s5, cur_s6, cur_s7;
	logic signed [CUR_W-1:0] ff_s1, ff_s2, ff_s3, ff_s4, ff_s5, ff_s6, ff_s7;
	logic signed [SPD_W-1:0] w_s1, w_s2;
	logic signed [31:0] cw_s2, ww_s2, cc_s2;
	logic signed [63:0] t0_s3, t1_s3, t2_s3;
	logic signed [47:0] kw_s3;
	logic signed [PWR_W-1:0] p_s4, p_s5, p_s6, p_s7;
	logic signed [PWR_W-1:0] b_s4, b_s5, b_s6, b_s7;
	logic signed [55:0] st_s4, st_s5;
	logic signed [49:0] sp_s5;
	logic signed [63:0] bb_s5, bb_s6, bb_s7;
	logic lim_s5, lim_s6, lim_s7;
	logic signed [PWR_W-1:0] c_s6;
	logic signed [63:0] kc_s7;
	logic [DISC_W-1:0] d_s8;
	item_t item_s8;

	logic signed [63:0] psum, csum, dval;

	assign cmd.ready = en;

	always_comb begin
		psum = (t0_s3 >>> 14) + (t1_s3 >>> 8) + (t2_s3 >>> 20) + 64'(cfg.a);
		csum = 64'(cfg.a) + 64'(st_s5) - 64'(sp_s5 >>> 16);
		dval = (bb_s7 >>> 2) - kc_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// capture beat
			cur_s1 <= cmd.command_current;
			ff_s1  <= cmd.extra_current;
			w_s1   <= cmd.shaft_speed;
			// narrow products
			cw_s2 <= cur_s1 * w_s1;
			ww_s2 <= w_s1 * w_s1;
			cc_s2 <= cur_s1 * cur_s1;
			cur_s2 <= cur_s1; ff_s2 <= ff_s1; w_s2 <= w_s1;
			// coefficient products
			t0_s3 <= cfg.k0 * cw_s2;
			t1_s3 <= cfg.k1 * ww_s2;
			t2_s3 <= cfg.k2 * cc_s2;
			kw_s3 <= cfg.k0 * w_s2;
			cur_s3 <= cur_s2; ff_s3 <= ff_s2;
			// estimate and linear coefficient
			p_s4  <= sat_s32(psum);
			st_s4 <= 56'(t1_s3 >>> 8);
			b_s4  <= sat_s32(64'(kw_s3 >>> 4));
			cur_s4 <= cur_s3; ff_s4 <= ff_s3;
			// allowed power and b squared
			sp_s5  <= $signed({1'b0, cfg.scale}) * p_s4;
			bb_s5  <= b_s4 * b_s4;
			lim_s5 <= cfg.enable && (p_s4 > 0) && (cfg.scale < SCALE_ONE);
			st_s5 <= st_s4; p_s5 <= p_s4; b_s5 <= b_s4; cur_s5 <= cur_s4; ff_s5 <= ff_s4;
			// constant term of the quadratic
			c_s6 <= sat_s32(csum);
			bb_s6 <= bb_s5; lim_s6 <= lim_s5; p_s6 <= p_s5; b_s6 <= b_s5;
			cur_s6 <= cur_s5; ff_s6 <= ff_s5;
			// K2 times c
			kc_s7 <= cfg.k2 * c_s6;
			bb_s7 <= bb_s6; lim_s7 <= lim_s6; p_s7 <= p_s6; b_s7 <= b_s6;
			cur_s7 <= cur_s6; ff_s7 <= ff_s6;
			// discriminant; clamp negative to zero, flagged below
			d_s8 <= dval[63] ? '0 : DISC_W'(dval);
			item_s8.cur     <= cur_s7;
			item_s8.ff      <= ff_s7;
			item_s8.p       <= p_s7;
			item_s8.b       <= b_s7;
			item_s8.applied <= lim_s7;
			item_s8.nosol   <= lim_s7 && (dval[63] || (cfg.k2 == '0));
		end
	end

	assign out_v    = v_s8;
	assign out_d    = d_s8;
	assign out_item = item_s8;

endmodule

`default_nettype wire

FILE: hw/rtl/mpl_sqrt.sv
// Bit-per-stage integer square root of the discriminant, side data alongside.
// Depends on mpl_pkg.
`default_nettype none

module mpl_sqrt #(
	parameter int SQRT_BITS = mpl_pkg::SQRT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_v,
	input  logic [mpl_pkg::DISC_W-1:0] in_d,
	input  mpl_pkg::item_t             in_item,
	output logic                       out_v,
	output logic [mpl_pkg::ROOT_W-1:0] out_root,
	output mpl_pkg::item_t             out_item
);
	import mpl_pkg::*;

	localparam int NB = (SQRT_BITS > ROOT_W) ? ROOT_W : SQRT_BITS;

	logic              v_s    [NB];
	logic [DISC_W-1:0] rem_s  [NB];
	logic [ROOT_W-1:0] root_s [NB];
	item_t             item_s [NB];

	for (genvar i = 0; i < NB; i++) begin : g_step
		localparam int K = NB - 1 - i;
		logic              v_in;
		logic [DISC_W-1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		item_t             item_in;
		logic [REM_W-1:0]  trial;

		if (i == 0) begin : g_first
			assign v_in    = in_v;
			assign rem_in  = in_d;
			assign root_in = '0;
			assign item_in = in_item;
		end else begin : g_next
			assign v_in    = v_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign item_in = item_s[i-1];
		end

		// (r + 2^K)^2 - r^2
		assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (REM_W'(rem_in) >= trial) begin
					rem_s[i]  <= rem_in - DISC_W'(trial);
					root_s[i] <= root_in | (ROOT_W'(1) << K);
				end else begin
					rem_s[i]  <= rem_in;
					root_s[i] <= root_in;
				end
				item_s[i] <= item_in;
			end
		end
	end

	assign out_v    = v_s[NB-1];
	assign out_root = root_s[NB-1];
	assign out_item = item_s[NB-1];

endmodule

`default_nettype wire

FILE: hw/rtl/mpl_div.sv
// Two-lane restoring divider for both roots, one quotient bit per stage.
// Depends on mpl_pkg.
`default_nettype none

module mpl_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic signed [mpl_pkg::DEN_W-1:0]  den,
	input  logic                              in_v,
	input  logic [mpl_pkg::ROOT_W-1:0]        in_root,
	input  mpl_pkg::item_t                    in_item,
	output logic                              out_v,
	output logic signed [mpl_pkg::NUM_W:0]    out_q1,
	output logic signed [mpl_pkg::NUM_W:0]    out_q2,
	output mpl_pkg::item_t                    out_item
);
	import mpl_pkg::*;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] num;
	} lane_t;

	function automatic lane_t div_step(input lane_t x, input logic [DEN_W-1:0] dv);
		logic [DEN_W:0] t;
		lane_t y;
		t = {x.rem, x.num[NUM_W-1]};
		if (t >= {1'b0, dv}) begin
			y.rem = DEN_W'(t - {1'b0, dv});
			y.num = {x.num[NUM_W-2:0], 1'b1};
		end else begin
			y.rem = t[DEN_W-1:0];
			y.num = {x.num[NUM_W-2:0], 1'b0};
		end
		return y;
	endfunction

	logic signed [DEN_W:0] den_x;
	logic [DEN_W-1:0]      den_mag;
	logic signed [NUM_W:0] h2, bx, n1, n2;

	assign den_x   = (DEN_W + 1)'(den);
	assign den_mag = den_x[DEN_W] ? DEN_W'(-den_x) : DEN_W'(den_x);

	always_comb begin
		h2 = (NUM_W + 1)'({in_root, 1'b0});
		bx = (NUM_W + 1)'(in_item.b);
		n1 = (h2 - bx) <<< 9;
		n2 = (-h2 - bx) <<< 9;
	end

	// entry stage: magnitudes and quotient signs
	logic  v_s1;
	lane_t l1_s1, l2_s1;
	logic  ng1_s1, ng2_s1;
	item_t item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l1_s1.rem <= '0;
			l2_s1.rem <= '0;
			l1_s1.num <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
			l2_s1.num <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
			ng1_s1    <= n1[NUM_W] ^ den[DEN_W-1];
			ng2_s1    <= n2[NUM_W] ^ den[DEN_W-1];
			item_s1   <= in_item;
		end
	end

	logic  v_s   [NUM_W];
	lane_t l1_s  [NUM_W];
	lane_t l2_s  [NUM_W];
	logic  ng1_s [NUM_W];
	logic  ng2_s [NUM_W];
	item_t item_s[NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_step
		logic  v_in, ng1_in, ng2_in;
		lane_t l1_in, l2_in;
		item_t item_in;

		if (i == 0) begin : g_first
			assign v_in = v_s1;     assign l1_in = l1_s1;   assign l2_in = l2_s1;
			assign ng1_in = ng1_s1; assign ng2_in = ng2_s1; assign item_in = item_s1;
		end else begin : g_next
			assign v_in = v_s[i-1];     assign l1_in = l1_s[i-1];   assign l2_in = l2_s[i-1];
			assign ng1_in = ng1_s[i-1]; assign ng2_in = ng2_s[i-1]; assign item_in = item_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= v_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				l1_s[i]   <= div_step(l1_in, den_mag);
				l2_s[i]   <= div_step(l2_in, den_mag);
				ng1_s[i]  <= ng1_in;
				ng2_s[i]  <= ng2_in;
				item_s[i] <= item_in;
			end
		end
	end

	// exit stage: restore signs, truncation toward zero
	logic                  v_s2;
	logic signed [NUM_W:0] q1_s2, q2_s2, a1, a2;
	item_t                 item_s2;

	assign a1 = $signed({1'b0, l1_s[NUM_W-1].num});
	assign a2 = $signed({1'b0, l2_s[NUM_W-1].num});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s[NUM_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q1_s2   <= ng1_s[NUM_W-1] ? -a1 : a1;
			q2_s2   <= ng2_s[NUM_W-1] ? -a2 : a2;
			item_s2 <= item_s[NUM_W-1];
		end
	end

	assign out_v    = v_s2;
	assign out_q1   = q1_s2;
	assign out_q2   = q2_s2;
	assign out_item = item_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/mpl_out.sv
// Back end: root choice, feedforward and clamp, drive scaling, output skid.
// Depends on mpl_pkg and mpl_out_if; sets the pipeline advance enable.
`default_nettype none

module mpl_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mpl_pkg::cfg_t                  cfg,
	input  logic                           in_v,
	input  logic signed [mpl_pkg::NUM_W:0] in_q1,
	input  logic signed [mpl_pkg::NUM_W:0] in_q2,
	input  mpl_pkg::item_t                 in_item,
	output logic                           en,
	mpl_out_if.source                      res
);
	import mpl_pkg::*;

	localparam int SUM_W = CUR_W + 1;
	localparam int PRD_W = LIMIT_W + GAIN_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [CUR_W-1:0] lc_s1, lc_s2, lc_s3, ff_s1;
	logic signed [PWR_W-1:0] p_s1, p_s2, p_s3;
	logic ap_s1, ap_s2, ap_s3, ns_s1, ns_s2, ns_s3;
	logic signed [SUM_W-1:0] sum_s2;
	logic [PRD_W-1:0] m_s3;
	logic neg_s3;
	res_t fin_s4;

	logic signed [NUM_W+1:0] e1, e2, ae1, ae2;
	logic signed [CUR_W-1:0] pick;
	logic signed [SUM_W-1:0] sraw, lim, smag;
	logic signed [PRD_W:0]   dsc;

	logic skid_v_q, out_v_q;
	res_t skid_q, out_q;

	always_comb begin
		e1  = (NUM_W + 2)'(in_q1) - (NUM_W + 2)'(in_item.cur);
		e2  = (NUM_W + 2)'(in_q2) - (NUM_W + 2)'(in_item.cur);
		ae1 = e1[NUM_W+1] ? -e1 : e1;
		ae2 = e2[NUM_W+1] ? -e2 : e2;
		if (!in_item.applied) pick = in_item.cur;
		else if (in_item.nosol) pick = '0;
		else if (ae1 < ae2) pick = sat_s16(64'(in_q1));
		else pick = sat_s16(64'(in_q2));

		sraw = SUM_W'(lc_s1) + SUM_W'(ff_s1);
		lim  = $signed({2'b0, cfg.limit});
		smag = sum_s2[SUM_W-1] ? -sum_s2 : sum_s2;
		dsc  = $signed({1'b0, PRD_W'(m_s3 >> 18)});
	end

	assign en = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lc_s1 <= pick; ff_s1 <= in_item.ff; p_s1 <= in_item.p;
			ap_s1 <= in_item.applied; ns_s1 <= in_item.nosol;

			if (sraw > lim) sum_s2 <= lim;
			else if (sraw < -lim) sum_s2 <= -lim;
			else sum_s2 <= sraw;
			lc_s2 <= lc_s1; p_s2 <= p_s1; ap_s2 <= ap_s1; ns_s2 <= ns_s1;

			m_s3   <= LIMIT_W'(smag) * cfg.gain;
			neg_s3 <= sum_s2[SUM_W-1];
			lc_s3 <= lc_s2; p_s3 <= p_s2; ap_s3 <= ap_s2; ns_s3 <= ns_s2;

			fin_s4.drive   <= sat_s16(64'(neg_s3 ? -dsc : dsc));
			fin_s4.lcur    <= lc_s3;
			fin_s4.p       <= p_s3;
			fin_s4.applied <= ap_s3;
			fin_s4.nosol   <= ns_s3;
		end
	end

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res.ready) begin
			out_v_q  <= skid_v_q || v_s4;
			skid_v_q <= 1'b0;
		end else if (v_s4 && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res.ready) begin
			out_q <= skid_v_q ? skid_q : fin_s4;
		end else if (v_s4 && !skid_v_q) begin
			skid_q <= fin_s4;
		end
	end

	assign res.valid           = out_v_q;
	assign res.drive_word      = out_q.drive;
	assign res.limited_current = out_q.lcur;
	assign res.power_est       = out_q.p;
	assign res.limit_applied   = out_q.applied;
	assign res.no_solution     = out_q.nosol;

endmodule

`default_nettype wire

FILE: hw/rtl/motor_power_limiter.sv
// Top level of the motor power limiter: configuration registers and the
// pipeline chain mpl_front, mpl_sqrt, mpl_div, mpl_out. Depends on mpl_pkg.
`default_nettype none

// The limiter takes one command beat per clock and returns one result beat per
// command, in order. It estimates motor power from the command current and
// shaft speed, and when limiting is enabled, the estimate is positive and
// power_scale is below 1.0, it replaces the command by the root of the power
// quadratic nearest to it (zero with no_solution set when there is no real
// root or K2 is zero). Feedforward is then added, the sum clamped to the
// current limit and scaled into a saturated drive word. Throughput is one beat
// per cycle unless the output stalls. The depth is set mostly by the square
// root and the two-lane divider, each of which resolves one result bit per
// pipeline stage. A stalled result waits in the output register while one more
// beat drains into a skid entry; cmd.ready drops only while that skid entry is
// full, and the whole pipeline holds then. Write configuration only while no
// beat is in flight.
module motor_power_limiter #(
	parameter int SQRT_BITS = mpl_pkg::SQRT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mpl_in_if.sink                          cmd,
	mpl_out_if.source                       res,
	input  logic                            wr_en,
	input  logic [mpl_pkg::CFG_IDX_W-1:0]   wr_index,
	input  logic [mpl_pkg::CFG_DATA_W-1:0]  wr_data
);
	import mpl_pkg::*;

	cfg_t cfg_q;
	logic en;

	logic              fr_v;
	logic [DISC_W-1:0] fr_d;
	item_t             fr_item;
	logic              sq_v;
	logic [ROOT_W-1:0] sq_root;
	item_t             sq_item;
	logic              dv_v;
	logic signed [NUM_W:0] dv_q1, dv_q2;
	item_t             dv_item;

	// register file; each write keeps only the register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k0     <= '0;
			cfg_q.k1     <= '0;
			cfg_q.k2     <= '0;
			cfg_q.a      <= '0;
			cfg_q.scale  <= SCALE_ONE;
			cfg_q.enable <= 1'b0;
			cfg_q.limit  <= LIMIT_RST;
			cfg_q.gain   <= GAIN_RST;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_K0:     cfg_q.k0     <= wr_data[COEF_W-1:0];
				CFG_K1:     cfg_q.k1     <= wr_data[COEF_W-1:0];
				CFG_K2:     cfg_q.k2     <= wr_data[COEF_W-1:0];
				CFG_A:      cfg_q.a      <= wr_data[COEF_W-1:0];
				CFG_SCALE:  cfg_q.scale  <= wr_data[SCALE_W-1:0];
				CFG_ENABLE: cfg_q.enable <= wr_data[0];
				CFG_LIMIT:  cfg_q.limit  <= wr_data[LIMIT_W-1:0];
				CFG_GAIN:   cfg_q.gain   <= wr_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// estimate and discriminant
	mpl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.out_v    (fr_v),
		.out_d    (fr_d),
		.out_item (fr_item)
	);

	// half of the root spread
	mpl_sqrt #(.SQRT_BITS(SQRT_BITS)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (fr_v),
		.in_d     (fr_d),
		.in_item  (fr_item),
		.out_v    (sq_v),
		.out_root (sq_root),
		.out_item (sq_item)
	);

	// both candidate roots divided by K2
	mpl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.den      (cfg_q.k2),
		.in_v     (sq_v),
		.in_root  (sq_root),
		.in_item  (sq_item),
		.out_v    (dv_v),
		.out_q1   (dv_q1),
		.out_q2   (dv_q2),
		.out_item (dv_item)
	);

	// choose, clamp, scale, deliver; drives the advance enable
	mpl_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_v    (dv_v),
		.in_q1   (dv_q1),
		.in_q2   (dv_q2),
		.in_item (dv_item),
		.en      (en),
		.res     (res)
	);

	// input holds off only behind a waiting result
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> res.valid)
		else $error("input stalled with no result pending");

	a_nosol_is_applied: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.no_solution |-> res.limit_applied)
		else $error("no_solution without limit_applied");

	a_nosol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.no_solution |-> res.limited_current == '0)
		else $error("no_solution with nonzero limited current");

endmodule

`default_nettype wire
